>>> rtl/owubm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owubm_pkg
// Shared types and constants of the 1-Wire over UART bit master.
// ----------------------------------------------------------------------------
package owubm_pkg;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   localparam logic [7:0] RESET_PATTERN = 8'hF0;
   localparam logic [7:0] SLOT_ONE      = 8'hFF;
   localparam logic [7:0] SLOT_ZERO     = 8'h00;

   typedef enum logic [2:0] {
      CMD_RESET   = 3'd0,
      CMD_WRITE   = 3'd1,
      CMD_READ    = 3'd2,
      CMD_ECHO    = 3'd3,
      CMD_TIMEOUT = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_WRITE = 2'd2,
      PH_READ  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TIMEOUT   = 2'd1,
      ST_NO_DEVICE = 2'd2
   } status_type;

   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bits_left;
      logic [7:0] shift_reg;
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       fast_baud;
      logic [7:0] read_byte;
      status_type status;
   } rsp_type;

endpackage

>>> rtl/owubm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owubm_step
// Next-state and result logic for one command or UART event.
// ----------------------------------------------------------------------------
module owubm_step
   import owubm_pkg::*;
(
   input  logic [2:0] cmd,
   input  logic [7:0] data_byte,
   input  state_type  state_cur,
   output state_type  state_nxt,
   output logic       has_rsp,
   output rsp_type    rsp
);

   logic       last;
   logic [3:0] bits_dec;
   logic [7:0] read_nxt;

   always_comb begin
      last     = (state_cur.bits_left <= 4'd1);
      bits_dec = last ? 4'd0 : state_cur.bits_left - 4'd1;
      read_nxt = {(data_byte == SLOT_ONE), state_cur.shift_reg[7:1]};

      state_nxt = state_cur;
      has_rsp   = 1'b0;
      rsp       = '{kind: KIND_TX, tx_byte: 8'd0, fast_baud: 1'b0,
                    read_byte: 8'd0, status: ST_OK};

      if (state_cur.phase == PH_IDLE) begin
         unique case (cmd)
            CMD_RESET: begin
               state_nxt.phase     = PH_RESET;
               state_nxt.bits_left = 4'd1;
               has_rsp             = 1'b1;
               rsp.tx_byte         = RESET_PATTERN;
            end
            CMD_WRITE: begin
               state_nxt.phase     = PH_WRITE;
               state_nxt.bits_left = BITS_PER_BYTE;
               state_nxt.shift_reg = data_byte >> 1;
               has_rsp             = 1'b1;
               rsp.tx_byte         = data_byte[0] ? SLOT_ONE : SLOT_ZERO;
               rsp.fast_baud       = 1'b1;
            end
            CMD_READ: begin
               state_nxt.phase     = PH_READ;
               state_nxt.bits_left = BITS_PER_BYTE;
               state_nxt.shift_reg = 8'd0;
               has_rsp             = 1'b1;
               rsp.tx_byte         = SLOT_ONE;
               rsp.fast_baud       = 1'b1;
            end
            default: ;
         endcase
      end else if (cmd == CMD_TIMEOUT) begin
         state_nxt.phase     = PH_IDLE;
         state_nxt.bits_left = 4'd0;
         has_rsp             = 1'b1;
         rsp.kind            = KIND_DONE;
         rsp.status          = ST_TIMEOUT;
      end else if (cmd == CMD_ECHO) begin
         has_rsp             = 1'b1;
         state_nxt.bits_left = bits_dec;
         unique case (state_cur.phase)
            PH_RESET: begin
               state_nxt.phase = PH_IDLE;
               rsp.kind        = KIND_DONE;
               rsp.status      = (data_byte == RESET_PATTERN) ? ST_NO_DEVICE : ST_OK;
            end
            PH_WRITE: begin
               if (last) begin
                  state_nxt.phase = PH_IDLE;
                  rsp.kind        = KIND_DONE;
               end else begin
                  state_nxt.shift_reg = state_cur.shift_reg >> 1;
                  rsp.tx_byte   = state_cur.shift_reg[0] ? SLOT_ONE : SLOT_ZERO;
                  rsp.fast_baud = 1'b1;
               end
            end
            default: begin
               // reading: new bit enters at the top
               state_nxt.shift_reg = read_nxt;
               if (last) begin
                  state_nxt.phase = PH_IDLE;
                  rsp.kind        = KIND_DONE;
                  rsp.read_byte   = read_nxt;
               end else begin
                  rsp.tx_byte   = SLOT_ONE;
                  rsp.fast_baud = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

>>> rtl/owubm_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owubm_rsp_fifo
// Two-entry result buffer that decouples the input side from rsp_ready.
// ----------------------------------------------------------------------------
module owubm_rsp_fifo
   import owubm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/onewire_uart_bit_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_uart_bit_master
// 1-Wire bus master that turns commands and UART echoes into UART slot bytes.
// ----------------------------------------------------------------------------
// results are registered in the result buffer and reach rsp_ in order, behind any earlier ones
// throughput: one request beat per cycle while req_ready is high; the state updates on each accepted beat
// req_ready drops only while both entries of the result buffer are full
// reset: synchronous; phase idle, slot counter and shift register cleared,
// result buffer emptied
module onewire_uart_bit_master
   import owubm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_fast_baud,
   output logic [7:0] rsp_read_byte,
   output logic [1:0] rsp_status
);

   state_type state_ff, state_in, state_nxt;
   logic      has_rsp;
   rsp_type   step_rsp;
   rsp_type   out_rsp;
   logic      full;
   logic      accept;

   assign req_ready = ~full;
   assign accept    = req_valid && req_ready;

   owubm_step u_step (
      .cmd       (req_cmd),
      .data_byte (req_data_byte),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .has_rsp   (has_rsp),
      .rsp       (step_rsp)
   );

   assign state_in = accept ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, bits_left: 4'd0, shift_reg: 8'd0};
      end else begin
         state_ff <= state_in;
      end
   end

   owubm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && has_rsp),
      .push_data (step_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_kind      = out_rsp.kind;
   assign rsp_tx_byte   = out_rsp.tx_byte;
   assign rsp_fast_baud = out_rsp.fast_baud;
   assign rsp_read_byte = out_rsp.read_byte;
   assign rsp_status    = out_rsp.status;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 1-Wire over UART bit master against a cycle-free model of its
// slot sequencing: directed bus resets, writes, reads and ignored commands,
// then random well-formed operations with timeouts and noise mixed in,
// under random request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import owubm_pkg::*;

   // codes the block leaves unused
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_cmd;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_kind;
   logic [7:0] rsp_tx_byte;
   logic       rsp_fast_baud;
   logic [7:0] rsp_read_byte;
   logic [1:0] rsp_status;

   onewire_uart_bit_master dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_fast_baud (rsp_fast_baud),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status)
   );

   // model of the bus master state
   phase_type  bus_phase;
   logic [3:0] slots_left;
   logic [7:0] slot_shift;

   rsp_type expected_slots[$];
   int      fail_count;
   int      result_beats;
   bit      req_gaps;
   bit      rsp_stalls;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit predict_bus_slot(input logic [2:0] cmd, input logic [7:0] dat,
                                           output rsp_type slot);
      bit last_slot;
      slot = '0;
      if (bus_phase == PH_IDLE) begin
         if (cmd == CMD_RESET) begin
            bus_phase  = PH_RESET;
            slots_left = 4'd1;
            slot.kind = KIND_TX;
            slot.tx_byte = RESET_PATTERN;
            return 1'b1;
         end
         if (cmd == CMD_WRITE) begin
            bus_phase  = PH_WRITE;
            slots_left = BITS_PER_BYTE;
            slot.kind = KIND_TX;
            slot.tx_byte = dat[0] ? SLOT_ONE : SLOT_ZERO;
            slot.fast_baud = 1'b1;
            slot_shift = dat >> 1;
            return 1'b1;
         end
         if (cmd == CMD_READ) begin
            bus_phase  = PH_READ;
            slots_left = BITS_PER_BYTE;
            slot_shift = 8'h00;
            slot.kind = KIND_TX;
            slot.tx_byte = SLOT_ONE;
            slot.fast_baud = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      end
      if (cmd == CMD_TIMEOUT) begin
         slot.kind = KIND_DONE;
         slot.status = ST_TIMEOUT;
         bus_phase  = PH_IDLE;
         slots_left = 4'd0;
         return 1'b1;
      end
      if (cmd != CMD_ECHO)
         return 1'b0;
      last_slot  = slots_left <= 4'd1;
      slots_left = last_slot ? 4'd0 : slots_left - 4'd1;
      case (bus_phase)
         PH_RESET: begin
            slot.kind = KIND_DONE;
            slot.status = (dat == RESET_PATTERN) ? ST_NO_DEVICE : ST_OK;
         end
         PH_WRITE: begin
            if (last_slot) begin
               slot.kind = KIND_DONE;
               slot.status = ST_OK;
            end else begin
               slot.kind = KIND_TX;
               slot.tx_byte = slot_shift[0] ? SLOT_ONE : SLOT_ZERO;
               slot.fast_baud = 1'b1;
               slot_shift = slot_shift >> 1;
            end
         end
         default: begin
            slot_shift = {dat == SLOT_ONE, slot_shift[7:1]};
            if (last_slot) begin
               slot.kind = KIND_DONE;
               slot.read_byte = slot_shift;
               slot.status = ST_OK;
            end else begin
               slot.kind = KIND_TX;
               slot.tx_byte = SLOT_ONE;
               slot.fast_baud = 1'b1;
            end
         end
      endcase
      if (slot.kind == KIND_DONE) begin
         bus_phase  = PH_IDLE;
         slots_left = 4'd0;
      end
      return 1'b1;
   endfunction

   task automatic send_beat(input logic [2:0] cmd, input logic [7:0] dat);
      rsp_type slot;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= dat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_bus_slot(cmd, dat, slot)) begin
         expected_slots.push_back(slot);
         result_beats++;
      end
   endtask

   function automatic logic [7:0] pick_echo();
      case ($urandom_range(0, 4))
         0: return SLOT_ZERO;
         1: return SLOT_ONE;
         2: return RESET_PATTERN;
         default: return 8'($urandom);
      endcase
   endfunction

   // result side: random stall bursts while enabled
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_slots.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected rsp beat kind=%0d tx=%02h", $realtime,
                        rsp_kind, rsp_tx_byte);
         end else begin
            want = expected_slots.pop_front();
            if (rsp_kind !== want.kind || rsp_tx_byte !== want.tx_byte ||
                rsp_fast_baud !== want.fast_baud || rsp_read_byte !== want.read_byte ||
                rsp_status !== want.status) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $write("%0t: rsp mismatch exp kind=%0d tx=%02h fast=%0d rd=%02h st=%0d",
                         $realtime, want.kind, want.tx_byte, want.fast_baud,
                         want.read_byte, want.status);
                  $display(" got kind=%0d tx=%02h fast=%0d rd=%02h st=%0d",
                           rsp_kind, rsp_tx_byte, rsp_fast_baud, rsp_read_byte,
                           rsp_status);
               end
            end
         end
      end
   end

   task automatic test_bus_reset();
      send_beat(CMD_RESET, 8'h00);
      send_beat(CMD_ECHO, RESET_PATTERN);
      send_beat(CMD_RESET, 8'hFF);
      send_beat(CMD_ECHO, SLOT_ZERO);
      // busy commands and a timeout mid-reset
      send_beat(CMD_RESET, 8'h3C);
      send_beat(CMD_WRITE, 8'h12);
      send_beat(CMD_SPARE_LAST, 8'hFF);
      send_beat(CMD_TIMEOUT, 8'h00);
   endtask

   task automatic test_write_byte();
      send_beat(CMD_WRITE, 8'h5A);
      for (int i = 0; i < 8; i++) begin
         if (i == 3)
            send_beat(CMD_READ, 8'hC3);
         send_beat(CMD_ECHO, i[0] ? SLOT_ONE : SLOT_ZERO);
      end
   endtask

   task automatic test_read_byte();
      logic [7:0] pattern;
      pattern = 8'b1011_0101;
      send_beat(CMD_READ, 8'hFF);
      for (int i = 0; i < 8; i++) begin
         if (i == 4)
            send_beat(CMD_SPARE_FIRST, 8'h80);
         send_beat(CMD_ECHO, pattern[i] ? SLOT_ONE : SLOT_ZERO);
      end
   endtask

   task automatic test_idle_noise();
      send_beat(CMD_ECHO, SLOT_ONE);
      send_beat(CMD_TIMEOUT, 8'hA5);
      send_beat(CMD_SPARE_LAST, 8'h00);
   endtask

   // random operations, mostly complete, some cut short by timeouts, with noise mixed in
   task automatic test_random_traffic(input int beats, input bit gaps, input bit stalls);
      int stop_at;
      req_gaps   = gaps;
      rsp_stalls = stalls;
      stop_at    = result_beats + beats;
      while (result_beats < stop_at) begin
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
               0: send_beat(CMD_ECHO, pick_echo());
               1: send_beat(CMD_TIMEOUT, 8'($urandom));
               default: send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                                  8'($urandom));
            endcase
         end else begin
            send_beat(3'($urandom_range(CMD_RESET, CMD_READ)), 8'($urandom));
         end
         while (bus_phase != PH_IDLE) begin
            case ($urandom_range(0, 39))
               0: send_beat(CMD_TIMEOUT, 8'($urandom));
               1: send_beat(3'($urandom_range(CMD_RESET, CMD_READ)), 8'($urandom));
               2: send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                            8'($urandom));
               default: send_beat(CMD_ECHO, pick_echo());
            endcase
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_RESET;
      req_data_byte <= 8'h00;
      bus_phase     = PH_IDLE;
      slots_left    = 4'd0;
      slot_shift    = 8'h00;
      fail_count    = 0;
      result_beats  = 0;
      req_gaps      = 1'b1;
      rsp_stalls    = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_bus_reset();
      test_write_byte();
      test_read_byte();
      test_idle_noise();
      test_random_traffic(350, 1'b1, 1'b1);
      test_random_traffic(150, 1'b0, 1'b1);
      test_random_traffic(150, 1'b1, 1'b0);
      test_random_traffic(120, 1'b1, 1'b1);
      test_random_traffic(150, 1'b0, 1'b0);

      req_valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
